/* design/fqsu_pkg.sv */
// Package for the FIFO queue with statistics unit.
// Holds field widths, command codes and the controller/datapath interface structs.
// No dependencies.
package fqsu_pkg;

  // Field widths
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned SUM_W     = 36;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned DEPTH_DEF = 16;

  // Command codes; code 3 acts as status only
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_STATUS = 2'd2
  } cmd_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic latch;   // capture the incoming word
    logic apply;   // apply push/pop, restart the scan
    logic scan;    // step the scan over the store
  } ctl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic scan_last;  // every held entry has been read
  } dp_stat_t;

endpackage

/* design/fqsu_ctrl.sv */
// Controller state machine for the FIFO queue with statistics unit.
// Sequences latch, apply, scan and result strobe. Depends on fqsu_pkg.
module fqsu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  output fqsu_pkg::ctl_cmd_t cmd_o,
  input  fqsu_pkg::dp_stat_t stat_i
);
  import fqsu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_APPLY;
            busy_q  <= 1'b1;
          end
        end
        ST_APPLY: begin
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (stat_i.scan_last) begin
            state_q <= ST_DONE;
            done_q  <= 1'b1;
          end
        end
        ST_DONE: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd_o.latch = start && (state_q == ST_IDLE);
    cmd_o.apply = (state_q == ST_APPLY);
    cmd_o.scan  = (state_q == ST_SCAN);
  end

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

/* design/fqsu_dpath.sv */
// Datapath for the FIFO queue with statistics unit: store, pointers,
// scan counter and statistic accumulators. Depends on fqsu_pkg.
module fqsu_dpath #(
  parameter int unsigned DEPTH = fqsu_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fqsu_pkg::ctl_cmd_t                cmd_i,
  output fqsu_pkg::dp_stat_t                stat_o,
  input  logic [fqsu_pkg::CMD_W-1:0]        command_i,
  input  logic signed [fqsu_pkg::VAL_W-1:0] push_value_i,
  output logic signed [fqsu_pkg::VAL_W-1:0] front_value_o,
  output logic                              not_empty_o,
  output logic [fqsu_pkg::OCC_W-1:0]        occupancy_o,
  output logic signed [fqsu_pkg::VAL_W-1:0] largest_o,
  output logic signed [fqsu_pkg::VAL_W-1:0] smallest_o,
  output logic signed [fqsu_pkg::SUM_W-1:0] total_sum_o,
  output logic signed [fqsu_pkg::SUM_W-1:0] odd_value_sum_o,
  output logic signed [fqsu_pkg::SUM_W-1:0] even_position_sum_o,
  output logic signed [fqsu_pkg::SUM_W-1:0] odd_position_sum_o,
  output logic                              op_error_o
);
  import fqsu_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned TSW   = CNT_W + 1;

  // Storage
  logic [VAL_W-1:0] mem [DEPTH];

  // Control registers
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q;
  logic [IDX_W-1:0] rd_ptr_q;
  logic             rd_vld_q;
  logic             err_q, err_d;

  // Payload registers
  logic [CMD_W-1:0]        cmd_q;
  logic [VAL_W-1:0]        val_q;
  logic signed [VAL_W-1:0] rd_data_q;
  logic                    pos_odd_q;
  logic                    first_q;
  logic signed [VAL_W-1:0] front_q, big_q, small_q;
  logic signed [SUM_W-1:0] total_q, oddv_q, evenp_q, oddp_q;

  logic             mem_we;
  logic [TSW-1:0]   tail_sum;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] rd_ptr_inc;
  logic             rd_en;
  logic signed [SUM_W-1:0] rd_ext;

  // Tail address, wrapped once into the store range
  always_comb begin
    tail_sum = TSW'(head_q) + TSW'(count_q);
    if (tail_sum >= TSW'(DEPTH)) begin
      tail_sum = tail_sum - TSW'(DEPTH);
    end
    wr_addr = tail_sum[IDX_W-1:0];
  end

  assign head_inc   = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign rd_ptr_inc = (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

  // Command effect on head, count and error
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    err_d   = 1'b0;
    mem_we  = 1'b0;
    unique case (cmd_q)
      CMD_PUSH: begin
        if (count_q == CNT_W'(DEPTH)) begin
          err_d = 1'b1;
        end else begin
          mem_we  = cmd_i.apply;
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP: begin
        if (count_q == '0) begin
          err_d = 1'b1;
        end else begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_en         = cmd_i.scan && (idx_q != count_q);
  assign stat_o.scan_last = (idx_q == count_q);
  assign rd_ext        = SUM_W'(rd_data_q);

  // Command capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= command_i;
      val_q <= push_value_i;
    end
  end

  // Queue pointers, error flag and scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      err_q    <= 1'b0;
      idx_q    <= '0;
      rd_ptr_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cmd_i.apply) begin
        head_q   <= head_d;
        count_q  <= count_d;
        err_q    <= err_d;
        idx_q    <= '0;
        rd_ptr_q <= head_d;
      end else if (rd_en) begin
        idx_q    <= idx_q + 1'b1;
        rd_ptr_q <= rd_ptr_inc;
      end
    end
  end

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= val_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  // Position tags follow the read word
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      pos_odd_q <= idx_q[0];
      first_q   <= (idx_q == '0);
    end
  end

  // Statistic accumulators, cleared at each new command
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      front_q <= '0;
      big_q   <= '0;
      small_q <= '0;
      total_q <= '0;
      oddv_q  <= '0;
      evenp_q <= '0;
      oddp_q  <= '0;
    end else if (rd_vld_q) begin
      if (first_q) begin
        front_q <= rd_data_q;
        big_q   <= rd_data_q;
        small_q <= rd_data_q;
      end else begin
        if (rd_data_q > big_q) begin
          big_q <= rd_data_q;
        end
        if (rd_data_q < small_q) begin
          small_q <= rd_data_q;
        end
      end
      total_q <= total_q + rd_ext;
      if (rd_data_q[0]) begin
        oddv_q <= oddv_q + rd_ext;
      end
      if (pos_odd_q) begin
        oddp_q <= oddp_q + rd_ext;
      end else begin
        evenp_q <= evenp_q + rd_ext;
      end
    end
  end

  // Result fields
  assign front_value_o       = front_q;
  assign not_empty_o         = (count_q != '0);
  assign occupancy_o         = OCC_W'(count_q);
  assign largest_o           = big_q;
  assign smallest_o          = small_q;
  assign total_sum_o         = total_q;
  assign odd_value_sum_o     = oddv_q;
  assign even_position_sum_o = evenp_q;
  assign odd_position_sum_o  = oddp_q;
  assign op_error_o          = err_q;

endmodule

/* design/fifo_queue_with_statistics_unit.sv */
// Sequence: the accepting edge latches the command; ST_APPLY applies it, ST_SCAN
// reads the held entries, and the result strobe is high in ST_DONE. A new word is
// accepted only in ST_IDLE; the scan after each command reads the store one entry per cycle.
// The receiver cannot stall: done_o is high for exactly one cycle per word.
// Reset (rst_ni low, asynchronous) empties the queue; store contents are not cleared.
// Top level: joins fqsu_ctrl and fqsu_dpath. Depends on fqsu_pkg.
module fifo_queue_with_statistics_unit #(
  parameter int unsigned DEPTH = fqsu_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  output logic                              done_o,
  input  logic [fqsu_pkg::CMD_W-1:0]        command_i,
  input  logic signed [fqsu_pkg::VAL_W-1:0] push_value_i,
  output logic signed [fqsu_pkg::VAL_W-1:0] front_value_o,
  output logic                              not_empty_o,
  output logic [fqsu_pkg::OCC_W-1:0]        occupancy_o,
  output logic signed [fqsu_pkg::VAL_W-1:0] largest_o,
  output logic signed [fqsu_pkg::VAL_W-1:0] smallest_o,
  output logic signed [fqsu_pkg::SUM_W-1:0] total_sum_o,
  output logic signed [fqsu_pkg::SUM_W-1:0] odd_value_sum_o,
  output logic signed [fqsu_pkg::SUM_W-1:0] even_position_sum_o,
  output logic signed [fqsu_pkg::SUM_W-1:0] odd_position_sum_o,
  output logic                              op_error_o
);
  import fqsu_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  // Sequencer
  fqsu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (ctl_cmd),
    .stat_i (dp_stat)
  );

  // Queue store and statistics
  fqsu_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (ctl_cmd),
    .stat_o              (dp_stat),
    .command_i           (command_i),
    .push_value_i        (push_value_i),
    .front_value_o       (front_value_o),
    .not_empty_o         (not_empty_o),
    .occupancy_o         (occupancy_o),
    .largest_o           (largest_o),
    .smallest_o          (smallest_o),
    .total_sum_o         (total_sum_o),
    .odd_value_sum_o     (odd_value_sum_o),
    .even_position_sum_o (even_position_sum_o),
    .odd_position_sum_o  (odd_position_sum_o),
    .op_error_o          (op_error_o)
  );

endmodule
